### rtl/complex_number_alu_assert.svh
// Assertion macros used by the RTL top level.
`ifndef COMPLEX_NUMBER_ALU_ASSERT_SVH
`define COMPLEX_NUMBER_ALU_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define CNA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cna assertion failed");

// Checked in the cycle after reset was high.
`define CNA_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("cna reset assertion failed");

`endif

### rtl/cna_pkg.sv
`default_nettype none
package cna_pkg;

   localparam int WORD_BITS    = 32;
   localparam int FRAC_BITS    = 16;  // below 30
   localparam int CORDIC_STEPS = 16;  // at most CELL_COUNT
   localparam int CELL_COUNT   = WORD_BITS;
   localparam int IDX_BITS     = $clog2(CELL_COUNT);
   localparam int PROD_BITS    = 2 * WORD_BITS;
   localparam int NUM_BITS     = PROD_BITS + 1;
   localparam int SPLIT_BITS   = WORD_BITS - FRAC_BITS;
   localparam int RROOT_BITS   = WORD_BITS + 4;
   localparam int VEC_BITS     = WORD_BITS + 4;
   localparam int ANG_BITS     = 34;
   localparam int ANG_FRAC     = 30;
   localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;

   localparam logic signed [ANG_BITS-1:0] PI_Q      = ANG_BITS'(64'sd3373259426);
   localparam logic signed [ANG_BITS-1:0] HALF_PI_Q = ANG_BITS'(64'sd1686629713);
   localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;

   typedef enum logic [3:0] {
      MODE_ADD   = 4'd0,
      MODE_SUB   = 4'd1,
      MODE_MUL   = 4'd2,
      MODE_DIV   = 4'd3,
      MODE_NEG   = 4'd4,
      MODE_CONJ  = 4'd5,
      MODE_MOD   = 4'd6,
      MODE_ARG   = 4'd7,
      MODE_EQUAL = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      CLS_DIRECT = 2'd0,
      CLS_DIV    = 2'd1,
      CLS_ROOT   = 2'd2,
      CLS_ANGLE  = 2'd3
   } op_class_type;

   typedef struct packed {
      logic [3:0]                  mode;
      logic signed [WORD_BITS-1:0] a_real;
      logic signed [WORD_BITS-1:0] a_imag;
      logic signed [WORD_BITS-1:0] b_real;
      logic signed [WORD_BITS-1:0] b_imag;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_real;
      logic signed [WORD_BITS-1:0] res_imag;
      logic                        is_equal;
      logic [1:0]                  status;
   } rsp_word_type;

   typedef struct packed {
      op_class_type                op_class;
      logic                        is_equal;
      logic [1:0]                  status;
      logic                        sat;
      logic signed [WORD_BITS-1:0] res_real;
      logic signed [WORD_BITS-1:0] res_imag;
      logic [PROD_BITS-1:0]        den;
      logic                        neg_re;
      logic                        neg_im;
      logic                        ovf_re;
      logic                        ovf_im;
      logic [PROD_BITS-1:0]        rem_re;
      logic [PROD_BITS-1:0]        rem_im;
      logic [WORD_BITS-1:0]        low_re;
      logic [WORD_BITS-1:0]        low_im;
      logic [WORD_BITS-1:0]        quo_re;
      logic [WORD_BITS-1:0]        quo_im;
      logic [PROD_BITS-1:0]        root_src;
      logic [RROOT_BITS-1:0]       root_rem;
      logic [WORD_BITS-1:0]        root;
      logic signed [VEC_BITS-1:0]  vx;
      logic signed [VEC_BITS-1:0]  vy;
      logic signed [ANG_BITS-1:0]  vz;
      logic                        vfixed;
   } cell_word_type;

   // atan(2^-i) in Q4.30
   function automatic logic [ANG_BITS-1:0] atan_q(input logic [IDX_BITS-1:0] idx);
      logic [ANG_BITS-1:0] v;
      case (int'(idx))
         0:  v = ANG_BITS'(843314856);
         1:  v = ANG_BITS'(497837829);
         2:  v = ANG_BITS'(263043836);
         3:  v = ANG_BITS'(133525158);
         4:  v = ANG_BITS'(67021686);
         5:  v = ANG_BITS'(33543515);
         6:  v = ANG_BITS'(16775850);
         7:  v = ANG_BITS'(8388437);
         8:  v = ANG_BITS'(4194282);
         9:  v = ANG_BITS'(2097149);
         10: v = ANG_BITS'(1048575);
         11: v = ANG_BITS'(524287);
         12: v = ANG_BITS'(262143);
         13: v = ANG_BITS'(131071);
         14: v = ANG_BITS'(65535);
         15: v = ANG_BITS'(32767);
         16: v = ANG_BITS'(16383);
         17: v = ANG_BITS'(8191);
         18: v = ANG_BITS'(4095);
         19: v = ANG_BITS'(2047);
         20: v = ANG_BITS'(1023);
         21: v = ANG_BITS'(511);
         22: v = ANG_BITS'(255);
         23: v = ANG_BITS'(127);
         24: v = ANG_BITS'(63);
         25: v = ANG_BITS'(31);
         26: v = ANG_BITS'(15);
         27: v = ANG_BITS'(7);
         28: v = ANG_BITS'(3);
         29: v = ANG_BITS'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### rtl/complex_number_alu.sv
// channel  direction  word           handshake
// req      in         req_word_type  req_valid, req_stall
// rsp      out        rsp_word_type  rsp_valid, rsp_stall
//
// One word per cycle sustained while rsp_stall is low: five front stages
// (operand register, 32x32 products, sums, magnitudes, quotient range check),
// one cell per quotient bit (32 cells, also root bits, first CORDIC_STEPS rotate), output.
// Reset is synchronous, active high, and empties every stage.
// Each stage takes a word when empty or when its successor moves, so bubbles
// close up while rsp_stall holds the output register.
`default_nettype none
`include "complex_number_alu_assert.svh"
module complex_number_alu import cna_pkg::*; (
   input  var logic         clock,
   input  var logic         reset,
   input  var logic         req_valid,
   output logic             req_stall,
   input  var req_word_type req_word,
   output logic             rsp_valid,
   input  var logic         rsp_stall,
   output rsp_word_type     rsp_word
);

   logic          chain_valid [0:CELL_COUNT];
   logic          chain_ready [0:CELL_COUNT];
   cell_word_type chain_word  [0:CELL_COUNT];
   logic          front_ready;
   logic          rsp_div_zero, rsp_sat, rsp_zero, rsp_at_bound;

   cna_front u_front (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (front_ready),
      .up_word    (req_word),
      .down_valid (chain_valid[0]),
      .down_ready (chain_ready[0]),
      .down_word  (chain_word[0])
   );

   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      cna_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .step_idx   (IDX_BITS'(k)),
         .up_valid   (chain_valid[k]),
         .up_ready   (chain_ready[k]),
         .up_word    (chain_word[k]),
         .down_valid (chain_valid[k+1]),
         .down_ready (chain_ready[k+1]),
         .down_word  (chain_word[k+1])
      );
   end

   cna_back u_back (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (chain_valid[CELL_COUNT]),
      .up_ready   (chain_ready[CELL_COUNT]),
      .up_word    (chain_word[CELL_COUNT]),
      .down_valid (rsp_valid),
      .down_ready (!rsp_stall),
      .down_word  (rsp_word)
   );

   assign req_stall = !front_ready;

   assign rsp_div_zero = rsp_valid && rsp_word.status == ST_DIV_ZERO;
   assign rsp_sat      = rsp_valid && rsp_word.status == ST_SAT;
   assign rsp_zero     = rsp_word.res_real == '0 && rsp_word.res_imag == '0;
   assign rsp_at_bound = rsp_word.res_real == WORD_MAX || rsp_word.res_real == WORD_MIN ||
                         rsp_word.res_imag == WORD_MAX || rsp_word.res_imag == WORD_MIN;

   `CNA_ASSERT_IMPL(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall)
   `CNA_ASSERT_IMPL(a_div_zero_clears, rsp_div_zero, rsp_zero)
   `CNA_ASSERT_IMPL(a_sat_at_bound, rsp_sat, rsp_at_bound)
   `CNA_ASSERT_AFTER_RESET(a_reset_empties, !rsp_valid && !req_stall)

endmodule
`default_nettype wire

### rtl/cna_front.sv
`default_nettype none
module cna_front import cna_pkg::*; (
   input  var logic          clock,
   input  var logic          reset,
   input  var logic          up_valid,
   output logic              up_ready,
   input  var req_word_type  up_word,
   output logic              down_valid,
   input  var logic          down_ready,
   output cell_word_type     down_word
);

   typedef struct packed {
      op_class_type                op_class;
      logic                        is_mul;
      logic                        is_equal;
      logic [1:0]                  status;
      logic                        sat;
      logic signed [WORD_BITS-1:0] res_real;
      logic signed [WORD_BITS-1:0] res_imag;
      logic signed [WORD_BITS-1:0] ar;
      logic signed [WORD_BITS-1:0] ai;
      logic signed [PROD_BITS-1:0] p_arbr;
      logic signed [PROD_BITS-1:0] p_aibi;
      logic signed [PROD_BITS-1:0] p_aibr;
      logic signed [PROD_BITS-1:0] p_arbi;
      logic signed [PROD_BITS-1:0] p_brbr;
      logic signed [PROD_BITS-1:0] p_bibi;
      logic signed [PROD_BITS-1:0] p_arar;
      logic signed [PROD_BITS-1:0] p_aiai;
   } front_b_type;

   typedef struct packed {
      op_class_type                op_class;
      logic                        is_mul;
      logic                        is_equal;
      logic [1:0]                  status;
      logic                        sat;
      logic signed [WORD_BITS-1:0] res_real;
      logic signed [WORD_BITS-1:0] res_imag;
      logic signed [WORD_BITS-1:0] ar;
      logic signed [WORD_BITS-1:0] ai;
      logic signed [NUM_BITS-1:0]  mre;
      logic signed [NUM_BITS-1:0]  mim;
      logic signed [NUM_BITS-1:0]  nre;
      logic signed [NUM_BITS-1:0]  nim;
      logic [PROD_BITS-1:0]        den;
      logic [PROD_BITS-1:0]        root_src;
   } front_c_type;

   typedef struct packed {
      op_class_type                op_class;
      logic                        is_equal;
      logic [1:0]                  status;
      logic                        sat;
      logic signed [WORD_BITS-1:0] res_real;
      logic signed [WORD_BITS-1:0] res_imag;
      logic                        neg_re;
      logic                        neg_im;
      logic [PROD_BITS-1:0]        mag_re;
      logic [PROD_BITS-1:0]        mag_im;
      logic [PROD_BITS-1:0]        den;
      logic [PROD_BITS-1:0]        root_src;
      logic signed [VEC_BITS-1:0]  vx;
      logic signed [VEC_BITS-1:0]  vy;
      logic signed [ANG_BITS-1:0]  vz;
      logic                        vfixed;
   } front_d_type;

   // {saturated, value}
   function automatic logic [WORD_BITS:0] clamp_word(input logic signed [NUM_BITS-1:0] v);
      logic [WORD_BITS:0] r;
      if ((&v[NUM_BITS-1:WORD_BITS-1]) || (~|v[NUM_BITS-1:WORD_BITS-1])) begin
         r = {1'b0, v[WORD_BITS-1:0]};
      end else if (v[NUM_BITS-1]) begin
         r = {1'b1, WORD_MIN};
      end else begin
         r = {1'b1, WORD_MAX};
      end
      return r;
   endfunction

   logic          a_valid_ff, a_valid_in, a_ready;
   req_word_type  a_word_ff;
   logic          b_valid_ff, b_valid_in, b_ready;
   front_b_type   b_word_ff, b_word_in;
   logic          c_valid_ff, c_valid_in, c_ready;
   front_c_type   c_word_ff, c_word_in;
   logic          d_valid_ff, d_valid_in, d_ready;
   front_d_type   d_word_ff, d_word_in;
   logic          e_valid_ff, e_valid_in, e_ready;
   cell_word_type e_word_ff, e_word_in;

   logic signed [WORD_BITS-1:0] ar, ai, br, bi;
   logic signed [WORD_BITS:0]   sre, sim;
   logic [WORD_BITS:0]          cl_re, cl_im, ml_re, ml_im;
   logic signed [NUM_BITS-1:0]  msh_re, msh_im;
   logic signed [VEC_BITS-1:0]  x0, y0;
   logic [PROD_BITS-1:0]        hi_re, hi_im;

   assign e_ready  = !e_valid_ff || down_ready;
   assign d_ready  = !d_valid_ff || e_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;

   assign a_valid_in = a_ready ? up_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;
   assign d_valid_in = d_ready ? c_valid_ff : d_valid_ff;
   assign e_valid_in = e_ready ? d_valid_ff : e_valid_ff;

   // products and the simple modes
   always_comb begin
      ar = a_word_ff.a_real;
      ai = a_word_ff.a_imag;
      br = a_word_ff.b_real;
      bi = a_word_ff.b_imag;
      sre = '0;
      sim = '0;
      b_word_in.op_class = CLS_DIRECT;
      b_word_in.is_mul   = 1'b0;
      b_word_in.status   = ST_OK;
      case (a_word_ff.mode)
         MODE_ADD: begin
            sre = ar + br;
            sim = ai + bi;
         end
         MODE_SUB: begin
            sre = ar - br;
            sim = ai - bi;
         end
         MODE_MUL: b_word_in.is_mul = 1'b1;
         MODE_DIV: begin
            if (br == '0 && bi == '0) begin
               b_word_in.status = ST_DIV_ZERO;
            end else begin
               b_word_in.op_class = CLS_DIV;
            end
         end
         MODE_NEG: begin
            sre = -ar;
            sim = -ai;
         end
         MODE_CONJ: begin
            sre = ar;
            sim = -ai;
         end
         MODE_MOD: b_word_in.op_class = CLS_ROOT;
         MODE_ARG: b_word_in.op_class = CLS_ANGLE;
         default: ;
      endcase
      cl_re = clamp_word(NUM_BITS'(sre));
      cl_im = clamp_word(NUM_BITS'(sim));
      b_word_in.sat      = cl_re[WORD_BITS] | cl_im[WORD_BITS];
      b_word_in.res_real = cl_re[WORD_BITS-1:0];
      b_word_in.res_imag = cl_im[WORD_BITS-1:0];
      b_word_in.is_equal = (ar == br) && (ai == bi);
      b_word_in.ar       = ar;
      b_word_in.ai       = ai;
      b_word_in.p_arbr   = ar * br;
      b_word_in.p_aibi   = ai * bi;
      b_word_in.p_aibr   = ai * br;
      b_word_in.p_arbi   = ar * bi;
      b_word_in.p_brbr   = br * br;
      b_word_in.p_bibi   = bi * bi;
      b_word_in.p_arar   = ar * ar;
      b_word_in.p_aiai   = ai * ai;
   end

   // sums
   always_comb begin
      c_word_in.op_class = b_word_ff.op_class;
      c_word_in.is_mul   = b_word_ff.is_mul;
      c_word_in.is_equal = b_word_ff.is_equal;
      c_word_in.status   = b_word_ff.status;
      c_word_in.sat      = b_word_ff.sat;
      c_word_in.res_real = b_word_ff.res_real;
      c_word_in.res_imag = b_word_ff.res_imag;
      c_word_in.ar       = b_word_ff.ar;
      c_word_in.ai       = b_word_ff.ai;
      c_word_in.mre      = b_word_ff.p_arbr - b_word_ff.p_aibi;
      c_word_in.mim      = b_word_ff.p_aibr + b_word_ff.p_arbi;
      c_word_in.nre      = b_word_ff.p_arbr + b_word_ff.p_aibi;
      c_word_in.nim      = b_word_ff.p_aibr - b_word_ff.p_arbi;
      c_word_in.den      = b_word_ff.p_brbr + b_word_ff.p_bibi;
      c_word_in.root_src = b_word_ff.p_arar + b_word_ff.p_aiai;
   end

   // product scaling, magnitudes, vector prestep
   always_comb begin
      msh_re = c_word_ff.mre >>> FRAC_BITS;
      msh_im = c_word_ff.mim >>> FRAC_BITS;
      ml_re  = clamp_word(msh_re);
      ml_im  = clamp_word(msh_im);
      d_word_in.op_class = c_word_ff.op_class;
      d_word_in.is_equal = c_word_ff.is_equal;
      d_word_in.status   = c_word_ff.status;
      if (c_word_ff.is_mul) begin
         d_word_in.sat      = ml_re[WORD_BITS] | ml_im[WORD_BITS];
         d_word_in.res_real = ml_re[WORD_BITS-1:0];
         d_word_in.res_imag = ml_im[WORD_BITS-1:0];
      end else begin
         d_word_in.sat      = c_word_ff.sat;
         d_word_in.res_real = c_word_ff.res_real;
         d_word_in.res_imag = c_word_ff.res_imag;
      end
      d_word_in.neg_re = c_word_ff.nre[NUM_BITS-1];
      d_word_in.neg_im = c_word_ff.nim[NUM_BITS-1];
      d_word_in.mag_re = c_word_ff.nre[NUM_BITS-1] ? PROD_BITS'(-c_word_ff.nre)
                                                   : PROD_BITS'(c_word_ff.nre);
      d_word_in.mag_im = c_word_ff.nim[NUM_BITS-1] ? PROD_BITS'(-c_word_ff.nim)
                                                   : PROD_BITS'(c_word_ff.nim);
      d_word_in.den      = c_word_ff.den;
      d_word_in.root_src = c_word_ff.root_src;
      x0 = VEC_BITS'(c_word_ff.ar);
      y0 = VEC_BITS'(c_word_ff.ai);
      d_word_in.vfixed = 1'b0;
      d_word_in.vx     = x0;
      d_word_in.vy     = y0;
      d_word_in.vz     = '0;
      if (c_word_ff.ai == '0) begin
         // on the real axis: 0 or pi, no iterations
         d_word_in.vfixed = 1'b1;
         d_word_in.vz     = c_word_ff.ar[WORD_BITS-1] ? PI_Q : '0;
      end else if (c_word_ff.ar[WORD_BITS-1]) begin
         if (!c_word_ff.ai[WORD_BITS-1]) begin
            d_word_in.vx = y0;
            d_word_in.vy = -x0;
            d_word_in.vz = HALF_PI_Q;
         end else begin
            d_word_in.vx = -y0;
            d_word_in.vy = x0;
            d_word_in.vz = -HALF_PI_Q;
         end
      end
   end

   // quotient range check and divider seed
   always_comb begin
      hi_re = d_word_ff.mag_re >> SPLIT_BITS;
      hi_im = d_word_ff.mag_im >> SPLIT_BITS;
      e_word_in.op_class = d_word_ff.op_class;
      e_word_in.is_equal = d_word_ff.is_equal;
      e_word_in.status   = d_word_ff.status;
      e_word_in.sat      = d_word_ff.sat;
      e_word_in.res_real = d_word_ff.res_real;
      e_word_in.res_imag = d_word_ff.res_imag;
      e_word_in.den      = d_word_ff.den;
      e_word_in.neg_re   = d_word_ff.neg_re;
      e_word_in.neg_im   = d_word_ff.neg_im;
      e_word_in.ovf_re   = hi_re >= d_word_ff.den;
      e_word_in.ovf_im   = hi_im >= d_word_ff.den;
      e_word_in.rem_re   = hi_re;
      e_word_in.rem_im   = hi_im;
      e_word_in.low_re   = WORD_BITS'(d_word_ff.mag_re << FRAC_BITS);
      e_word_in.low_im   = WORD_BITS'(d_word_ff.mag_im << FRAC_BITS);
      e_word_in.quo_re   = '0;
      e_word_in.quo_im   = '0;
      e_word_in.root_src = d_word_ff.root_src;
      e_word_in.root_rem = '0;
      e_word_in.root     = '0;
      e_word_in.vx       = d_word_ff.vx;
      e_word_in.vy       = d_word_ff.vy;
      e_word_in.vz       = d_word_ff.vz;
      e_word_in.vfixed   = d_word_ff.vfixed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_word_ff <= up_word;
      end
      if (b_ready) begin
         b_word_ff <= b_word_in;
      end
      if (c_ready) begin
         c_word_ff <= c_word_in;
      end
      if (d_ready) begin
         d_word_ff <= d_word_in;
      end
      if (e_ready) begin
         e_word_ff <= e_word_in;
      end
   end

   assign down_valid = e_valid_ff;
   assign down_word  = e_word_ff;

endmodule
`default_nettype wire

### rtl/cna_cell.sv
`default_nettype none
module cna_cell import cna_pkg::*; (
   input  var logic                clock,
   input  var logic                reset,
   input  var logic [IDX_BITS-1:0] step_idx,
   input  var logic                up_valid,
   output logic                    up_ready,
   input  var cell_word_type       up_word,
   output logic                    down_valid,
   input  var logic                down_ready,
   output cell_word_type           down_word
);

   logic          valid_ff, valid_in;
   cell_word_type word_ff, word_in;

   logic [PROD_BITS:0]          dtr_re, dtr_im, den_x;
   logic [RROOT_BITS-1:0]       rtr, rtrial;
   logic signed [VEC_BITS-1:0]  dx, dy;
   logic signed [ANG_BITS-1:0]  step_ang;
   logic                        cordic_on;

   // one quotient bit per lane, one root bit, one rotation unless vfixed or past CORDIC_STEPS
   always_comb begin
      word_in = up_word;
      den_x   = {1'b0, up_word.den};

      dtr_re = {up_word.rem_re, up_word.low_re[WORD_BITS-1]};
      if (dtr_re >= den_x) begin
         word_in.rem_re = PROD_BITS'(dtr_re - den_x);
         word_in.quo_re = {up_word.quo_re[WORD_BITS-2:0], 1'b1};
      end else begin
         word_in.rem_re = dtr_re[PROD_BITS-1:0];
         word_in.quo_re = {up_word.quo_re[WORD_BITS-2:0], 1'b0};
      end
      word_in.low_re = {up_word.low_re[WORD_BITS-2:0], 1'b0};

      dtr_im = {up_word.rem_im, up_word.low_im[WORD_BITS-1]};
      if (dtr_im >= den_x) begin
         word_in.rem_im = PROD_BITS'(dtr_im - den_x);
         word_in.quo_im = {up_word.quo_im[WORD_BITS-2:0], 1'b1};
      end else begin
         word_in.rem_im = dtr_im[PROD_BITS-1:0];
         word_in.quo_im = {up_word.quo_im[WORD_BITS-2:0], 1'b0};
      end
      word_in.low_im = {up_word.low_im[WORD_BITS-2:0], 1'b0};

      rtr    = {up_word.root_rem[RROOT_BITS-3:0], up_word.root_src[PROD_BITS-1 -: 2]};
      rtrial = RROOT_BITS'({up_word.root, 2'b01});
      if (rtr >= rtrial) begin
         word_in.root_rem = rtr - rtrial;
         word_in.root     = {up_word.root[WORD_BITS-2:0], 1'b1};
      end else begin
         word_in.root_rem = rtr;
         word_in.root     = {up_word.root[WORD_BITS-2:0], 1'b0};
      end
      word_in.root_src = {up_word.root_src[PROD_BITS-3:0], 2'b00};

      dx        = $signed(up_word.vy) >>> step_idx;
      dy        = $signed(up_word.vx) >>> step_idx;
      step_ang  = atan_q(step_idx);
      cordic_on = !up_word.vfixed && (int'(step_idx) < CORDIC_STEPS);
      if (cordic_on) begin
         if (!up_word.vy[VEC_BITS-1]) begin
            word_in.vx = up_word.vx + dx;
            word_in.vy = up_word.vy - dy;
            word_in.vz = up_word.vz + step_ang;
         end else begin
            word_in.vx = up_word.vx - dx;
            word_in.vy = up_word.vy + dy;
            word_in.vz = up_word.vz - step_ang;
         end
      end
   end

   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         word_ff <= word_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_word  = word_ff;

endmodule
`default_nettype wire

### rtl/cna_back.sv
`default_nettype none
module cna_back import cna_pkg::*; (
   input  var logic          clock,
   input  var logic          reset,
   input  var logic          up_valid,
   output logic              up_ready,
   input  var cell_word_type up_word,
   output logic              down_valid,
   input  var logic          down_ready,
   output rsp_word_type      down_word
);

   // {saturated, value} from quotient magnitude and sign
   function automatic logic [WORD_BITS:0] div_fix(input logic neg, input logic ovf,
                                                  input logic [WORD_BITS-1:0] q);
      logic [WORD_BITS:0] r;
      if (!neg) begin
         if (ovf || q[WORD_BITS-1]) begin
            r = {1'b1, WORD_MAX};
         end else begin
            r = {1'b0, q};
         end
      end else begin
         if (ovf || (q[WORD_BITS-1] && |q[WORD_BITS-2:0])) begin
            r = {1'b1, WORD_MIN};
         end else begin
            r = {1'b0, -q};
         end
      end
      return r;
   endfunction

   localparam logic signed [ANG_BITS-1:0] ANG_HALF = ANG_BITS'(1) << (ANG_SHIFT - 1);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   logic [WORD_BITS:0]         fx_re, fx_im;
   logic signed [ANG_BITS-1:0] ang_r;
   logic                       sat;

   always_comb begin
      fx_re = div_fix(up_word.neg_re, up_word.ovf_re, up_word.quo_re);
      fx_im = div_fix(up_word.neg_im, up_word.ovf_im, up_word.quo_im);
      ang_r = (up_word.vz + ANG_HALF) >>> ANG_SHIFT;
      sat   = up_word.sat;
      word_in.is_equal = up_word.is_equal;
      word_in.res_real = up_word.res_real;
      word_in.res_imag = up_word.res_imag;
      case (up_word.op_class)
         CLS_DIV: begin
            word_in.res_real = fx_re[WORD_BITS-1:0];
            word_in.res_imag = fx_im[WORD_BITS-1:0];
            sat              = fx_re[WORD_BITS] | fx_im[WORD_BITS];
         end
         CLS_ROOT: begin
            word_in.res_imag = '0;
            if (up_word.root[WORD_BITS-1]) begin
               word_in.res_real = WORD_MAX;
               sat              = 1'b1;
            end else begin
               word_in.res_real = up_word.root;
            end
         end
         CLS_ANGLE: begin
            word_in.res_real = WORD_BITS'(ang_r);
            word_in.res_imag = '0;
         end
         default: ;
      endcase
      word_in.status = sat ? ST_SAT : up_word.status;
   end

   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         word_ff <= word_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_word  = word_ff;

endmodule
`default_nettype wire
